FILE: rtl/node_status_response_parser_macros.svh
// Assertion macros shared by the name status response parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef NODE_STATUS_RESPONSE_PARSER_MACROS_SVH
`define NODE_STATUS_RESPONSE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset.
`define NSRP_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("nsrp assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define NSRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsrp assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define NSRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsrp assertion failed");
`else
`define NSRP_ASSERT(lbl, clk, rst, expr)
`define NSRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define NSRP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/nsrp_pkg.sv
// Types and constants of the name status response parser.
// No dependencies; imported by every module of the block.
package nsrp_pkg;

   // Datagram layout.
   localparam int unsigned COUNT_W = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 11'd2047;
   localparam logic [COUNT_W-1:0] TRN_END_POS    = 11'd2;
   localparam logic [COUNT_W-1:0] TYPE_POS       = 11'd46;
   localparam logic [COUNT_W-1:0] TYPE_LOW_POS   = 11'd47;
   localparam logic [COUNT_W-1:0] COUNT_POS      = 11'd56;
   localparam logic [COUNT_W-1:0] NAMES_POS      = 11'd57;
   localparam logic [COUNT_W-1:0] MIN_TYPED_LEN  = 11'd48;
   localparam logic [12:0]        FIXED_LEN      = 13'd103;
   localparam logic [15:0]        STATUS_RECORD_TYPE = 16'h0021;

   // Positions within one name entry.
   localparam logic [4:0] NAME_BYTES     = 5'd15;
   localparam logic [4:0] SUFFIX_POS     = 5'd15;
   localparam logic [4:0] FLAGS_HIGH_POS = 5'd16;
   localparam logic [4:0] LAST_ENTRY_POS = 5'd17;
   localparam logic [4:0] UNIT_ID_BYTES  = 5'd6;

   localparam logic [9:0] MAX_BYTES_RESET = 10'd576;

   typedef enum logic [1:0] {
      KIND_NAME_BYTE  = 2'd0,
      KIND_ENTRY_END  = 2'd1,
      KIND_PACKET_END = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LONG  = 2'd1,
      STATUS_BAD_TYPE  = 2'd2,
      STATUS_BAD_LEN   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] entry_index;
      logic [7:0] data_byte;
      logic       group_flag;
      logic [1:0] owner_type;
      logic       deregister_flag;
      logic       conflict_flag;
      logic       active_flag;
      logic       permanent_flag;
      status_type status;
      logic [47:0] hw_address;
      logic [15:0] transaction_id;
   } rsp_type;

endpackage

FILE: rtl/node_status_response_parser.sv
// Channel  Direction  Word         Handshake
// req      in         req_type     req_valid / req_stall
// rsp      out        rsp_type     rsp_valid / rsp_stall
// csr      in         10-bit limit csr_valid / csr_ready
//
// One datagram byte is taken every cycle unless req_stall is high; its result,
// if any, reaches the rsp port from the result register, via the skid entry
// when that register is held. Throughput is one word per cycle while req_stall
// is low; nsrp_parse forms the result combinationally for that register.
// Synchronous active-high reset clears capture state and sets the length limit
// to 576. A stalled result is held and one more is parked in the skid entry;
// req_stall rises only while that entry is occupied.
// Top level of the name status response parser.
// Depends on nsrp_pkg, nsrp_parse and nsrp_skid.
module node_status_response_parser import nsrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_data
);

   logic [9:0] max_limit_ff;
   logic       accept;
   logic       res_valid;
   rsp_type    res_word;
   logic       skid_full;

   // Length limit register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_limit_ff <= MAX_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         max_limit_ff <= csr_data;
      end
   end

   // The input stalls only while the skid entry holds a word.
   assign req_stall = skid_full;
   assign accept    = req_valid && !req_stall;

   nsrp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_data),
      .max_bytes (max_limit_ff),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   nsrp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_word   (res_word),
      .full      (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

FILE: rtl/nsrp_parse.sv
// Field capture and result formation for one datagram byte.
// Depends on nsrp_pkg and the assertion macro header.
`include "node_status_response_parser_macros.svh"

module nsrp_parse import nsrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_word,
   input  logic [9:0] max_bytes,
   output logic       res_valid,
   output rsp_type    res_word
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0] trn_id_ff, trn_id_in;
   logic [15:0] record_type_ff, record_type_in;
   logic [7:0]  name_count_ff, name_count_in;
   logic [7:0]  entry_counter_ff, entry_counter_in;
   logic [4:0]  entry_byte_pos_ff, entry_byte_pos_in;
   logic [7:0]  suffix_ff, suffix_in;
   logic [7:0]  flags_high_ff, flags_high_in;
   logic [47:0] unit_id_ff, unit_id_in;
   logic        type_error_ff, type_error_in;
   logic        too_long_ff, too_long_in;

   logic [COUNT_W-1:0] pos;
   logic [COUNT_W-1:0] len;
   logic [12:0] expect_len;
   logic        in_body;
   logic        in_entries;
   logic        emit;
   status_type  status;

   // Per-byte update of the captured header fields and entry position.
   always_comb begin
      pos = byte_count_ff;
      len = (byte_count_ff < COUNT_MAX) ? byte_count_ff + 11'd1 : byte_count_ff;
      byte_count_in = len;

      too_long_in   = too_long_ff | (len > {1'b0, max_bytes});
      trn_id_in     = trn_id_ff;
      record_type_in = record_type_ff;
      type_error_in = type_error_ff;
      name_count_in = name_count_ff;
      entry_counter_in = entry_counter_ff;
      entry_byte_pos_in = entry_byte_pos_ff;
      suffix_in     = suffix_ff;
      flags_high_in = flags_high_ff;
      unit_id_in    = unit_id_ff;

      in_body    = (pos >= NAMES_POS);
      in_entries = in_body && (entry_counter_ff < name_count_ff);
      emit       = !type_error_ff && !too_long_in && !req_word.in_last;

      res_valid = 1'b0;
      res_word  = '0;

      if (pos < TRN_END_POS) begin
         trn_id_in = {trn_id_ff[7:0], req_word.in_byte};
      end else if (pos == TYPE_POS || pos == TYPE_LOW_POS) begin
         record_type_in = {record_type_ff[7:0], req_word.in_byte};
         if (pos == TYPE_LOW_POS && record_type_in != STATUS_RECORD_TYPE) begin
            type_error_in = 1'b1;
         end
      end else if (pos == COUNT_POS) begin
         name_count_in = req_word.in_byte;
      end else if (in_entries) begin
         if (entry_byte_pos_ff < NAME_BYTES) begin
            res_valid            = emit;
            res_word.kind        = KIND_NAME_BYTE;
            res_word.entry_index = entry_counter_ff;
            res_word.data_byte   = req_word.in_byte;
            entry_byte_pos_in    = entry_byte_pos_ff + 5'd1;
         end else if (entry_byte_pos_ff == SUFFIX_POS) begin
            suffix_in         = req_word.in_byte;
            entry_byte_pos_in = entry_byte_pos_ff + 5'd1;
         end else if (entry_byte_pos_ff == FLAGS_HIGH_POS) begin
            flags_high_in     = req_word.in_byte;
            entry_byte_pos_in = entry_byte_pos_ff + 5'd1;
         end else begin
            res_valid                = emit;
            res_word.kind            = KIND_ENTRY_END;
            res_word.entry_index     = entry_counter_ff;
            res_word.data_byte       = suffix_ff;
            res_word.group_flag      = flags_high_ff[7];
            res_word.owner_type      = flags_high_ff[6:5];
            res_word.deregister_flag = flags_high_ff[4];
            res_word.conflict_flag   = flags_high_ff[3];
            res_word.active_flag     = flags_high_ff[2];
            res_word.permanent_flag  = flags_high_ff[1];
            entry_counter_in         = entry_counter_ff + 8'd1;
            entry_byte_pos_in        = '0;
         end
      end else if (in_body && entry_byte_pos_ff < UNIT_ID_BYTES) begin
         unit_id_in        = {unit_id_ff[39:0], req_word.in_byte};
         entry_byte_pos_in = entry_byte_pos_ff + 5'd1;
      end

      // Expected length is 103 plus 18 bytes per name entry.
      expect_len = FIXED_LEN + {1'b0, name_count_in, 4'b0000}
                 + {4'b0000, name_count_in, 1'b0};

      if (too_long_in) begin
         status = STATUS_TOO_LONG;
      end else if (type_error_in || len < MIN_TYPED_LEN) begin
         status = STATUS_BAD_TYPE;
      end else if ({2'b00, len} != expect_len) begin
         status = STATUS_BAD_LEN;
      end else begin
         status = STATUS_OK;
      end

      // The final byte reports the packet and clears all capture state.
      if (req_word.in_last) begin
         res_valid               = 1'b1;
         res_word                = '0;
         res_word.kind           = KIND_PACKET_END;
         res_word.status         = status;
         res_word.hw_address     = unit_id_in;
         res_word.transaction_id = trn_id_in;
         byte_count_in     = '0;
         trn_id_in         = '0;
         record_type_in    = '0;
         name_count_in     = '0;
         entry_counter_in  = '0;
         entry_byte_pos_in = '0;
         suffix_in         = '0;
         flags_high_in     = '0;
         unit_id_in        = '0;
         type_error_in     = 1'b0;
         too_long_in       = 1'b0;
      end

      res_valid = res_valid & accept;
   end

   // Capture state advances only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff     <= '0;
         trn_id_ff         <= '0;
         record_type_ff    <= '0;
         name_count_ff     <= '0;
         entry_counter_ff  <= '0;
         entry_byte_pos_ff <= '0;
         suffix_ff         <= '0;
         flags_high_ff     <= '0;
         unit_id_ff        <= '0;
         type_error_ff     <= 1'b0;
         too_long_ff       <= 1'b0;
      end else if (accept) begin
         byte_count_ff     <= byte_count_in;
         trn_id_ff         <= trn_id_in;
         record_type_ff    <= record_type_in;
         name_count_ff     <= name_count_in;
         entry_counter_ff  <= entry_counter_in;
         entry_byte_pos_ff <= entry_byte_pos_in;
         suffix_ff         <= suffix_in;
         flags_high_ff     <= flags_high_in;
         unit_id_ff        <= unit_id_in;
         type_error_ff     <= type_error_in;
         too_long_ff       <= too_long_in;
      end
   end

   `NSRP_ASSERT(a_entry_pos_range, clock, reset, entry_byte_pos_ff <= LAST_ENTRY_POS)
   `NSRP_ASSERT(a_entry_count_bound, clock, reset, entry_counter_ff <= name_count_ff)
   `NSRP_ASSERT_NEXT(a_clear_after_last, clock, reset, accept && req_word.in_last,
      byte_count_ff == '0 && entry_counter_ff == '0 && !too_long_ff)

endmodule

FILE: rtl/nsrp_skid.sv
// Result register with one skid entry between the parser and the result port.
// Depends on nsrp_pkg and the assertion macro header.
`include "node_status_response_parser_macros.svh"

module nsrp_skid import nsrp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_word,
   output logic    full,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_take;

   // Route a new word to the output register, or park it when that is held.
   always_comb begin
      out_take      = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = in_word;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_word;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `NSRP_ASSERT_IMPLY(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `NSRP_ASSERT_IMPLY(a_no_word_when_full, clock, reset, skid_valid_ff, !in_valid)
   `NSRP_ASSERT_IMPLY(a_skid_fill, clock, reset, $rose(skid_valid_ff),
      $past(out_valid_ff && rsp_stall))

endmodule
